/* hw/rtl/hte_pkg.sv */
package hte_pkg;

  localparam int MaxInputs = 4;
  localparam int MaxLevels = 4;
  localparam int ThrW      = 16;
  localparam int LvlIdxW   = 2;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 64;
  localparam int NowW      = 32;
  localparam int EvW       = MaxInputs * MaxLevels;

  typedef enum logic [CfgIdxW-1:0] {
    RegEnable    = 3'd0,
    RegThr0      = 3'd1,
    RegThr1      = 3'd2,
    RegThr2      = 3'd3,
    RegThr3      = 3'd4,
    RegGroupMode = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [MaxInputs-1:0]                       enable;
    logic [MaxInputs-1:0][MaxLevels-1:0][ThrW-1:0] thr;
    logic                                       group_mode;
  } cfg_t;

  // per-input and per-level flags, level bits at 4k+i
  typedef struct packed {
    logic [MaxInputs-1:0] pressed;
    logic [EvW-1:0]       reached;
    logic [MaxInputs-1:0] g_active;
    logic [EvW-1:0]       g_reached;
    logic [EvW-1:0]       g_hold;
    logic [MaxInputs-1:0] g_released;
  } flags_t;

  typedef struct packed {
    logic [EvW-1:0]       fired;
    logic [MaxInputs-1:0] release_ev;
    logic [MaxInputs-1:0] active;
    logic [EvW-1:0]       reached;
    logic [EvW-1:0]       hold;
    logic [MaxInputs-1:0] released;
  } res_t;

endpackage

/* hw/rtl/hte_cfg_regs.sv */
module hte_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [hte_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hte_pkg::CfgDataW-1:0] cfg_data_i,
  output hte_pkg::cfg_t                cfg_o
);
  import hte_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= cfg_t'{enable: '0, thr: '0, group_mode: 1'b1};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegEnable:    cfg_q.enable     <= cfg_data_i[MaxInputs-1:0];
        RegThr0:      cfg_q.thr[0]     <= cfg_data_i;
        RegThr1:      cfg_q.thr[1]     <= cfg_data_i;
        RegThr2:      cfg_q.thr[2]     <= cfg_data_i;
        RegThr3:      cfg_q.thr[3]     <= cfg_data_i;
        RegGroupMode: cfg_q.group_mode <= cfg_data_i[0];
        default: begin
          // unmapped index: dropped
        end
      endcase
    end
  end

endmodule

/* hw/rtl/hte_step.sv */
module hte_step #(
  parameter int NUM_INPUTS = 4,
  parameter int NUM_LEVELS = 4,
  parameter int TIME_WIDTH = 32
) (
  input  hte_pkg::cfg_t                       cfg_i,
  input  hte_pkg::flags_t                     flags_i,
  input  logic [TIME_WIDTH-1:0]               start_i [NUM_INPUTS],
  input  logic [hte_pkg::MaxInputs-1:0]       levels_i,
  input  logic [hte_pkg::NowW-1:0]            now_i,
  output hte_pkg::flags_t                     flags_o,
  output logic [TIME_WIDTH-1:0]               start_o [NUM_INPUTS],
  output hte_pkg::res_t                       res_o
);
  import hte_pkg::*;

  logic [TIME_WIDTH-1:0] now_t;
  logic [EvW-1:0]        fired;
  logic [MaxInputs-1:0]  rel;

  assign now_t = TIME_WIDTH'(now_i);

  always_comb begin
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  pass;
    logic [ThrW-1:0]       t_cur;
    logic [ThrW-1:0]       t_nxt;
    logic                  any_reached;
    elapsed     = '0;
    pass        = 1'b0;
    t_cur       = '0;
    t_nxt       = '0;
    any_reached = 1'b0;
    flags_o     = flags_i;
    start_o     = start_i;
    fired       = '0;
    rel         = '0;
    for (int i = 0; i < NUM_INPUTS; i++) begin
      if (cfg_i.enable[i]) begin
        if (levels_i[i]) begin
          if (!flags_i.pressed[i]) begin
            flags_o.pressed[i] = 1'b1;
            start_o[i]         = now_t;
          end
          elapsed = now_t - start_o[i];
          if (cfg_i.group_mode) flags_o.g_active[i] = 1'b1;
          pass = 1'b1;
          // level k counts only while every lower level has passed
          for (int k = 0; k < NUM_LEVELS; k++) begin
            t_cur = cfg_i.thr[i][k];
            t_nxt = cfg_i.thr[i][LvlIdxW'(k + 1)];
            pass  = pass && (t_cur != '0) && (elapsed >= TIME_WIDTH'(t_cur));
            if (pass) begin
              if (!flags_i.reached[MaxInputs*k+i]) begin
                flags_o.reached[MaxInputs*k+i] = 1'b1;
                fired[MaxInputs*k+i]           = 1'b1;
                if (cfg_i.group_mode) flags_o.g_reached[MaxInputs*k+i] = 1'b1;
              end
              if (cfg_i.group_mode) begin
                if (k + 1 < NUM_LEVELS) begin
                  if ((t_nxt != '0) && (elapsed < TIME_WIDTH'(t_nxt)))
                    flags_o.g_hold[MaxInputs*k+i] = 1'b1;
                end else begin
                  flags_o.g_hold[MaxInputs*k+i] = 1'b1;
                end
                if (k == 0) flags_o.g_released[i] = 1'b0;
              end
            end
          end
        end else begin
          if (cfg_i.group_mode) flags_o.g_active[i] = 1'b0;
          if (flags_i.pressed[i]) begin
            flags_o.pressed[i] = 1'b0;
            any_reached = 1'b0;
            for (int k = 0; k < MaxLevels; k++) begin
              any_reached = any_reached | flags_i.reached[MaxInputs*k+i];
              flags_o.reached[MaxInputs*k+i] = 1'b0;
              if (cfg_i.group_mode) flags_o.g_reached[MaxInputs*k+i] = 1'b0;
            end
            if (any_reached) begin
              rel[i] = 1'b1;
              if (cfg_i.group_mode) flags_o.g_released[i] = 1'b1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    res_o.fired      = fired;
    res_o.release_ev = rel;
    res_o.active     = cfg_i.group_mode ? flags_o.g_active   : '0;
    res_o.reached    = cfg_i.group_mode ? flags_o.g_reached  : '0;
    res_o.hold       = cfg_i.group_mode ? flags_o.g_hold     : '0;
    res_o.released   = cfg_i.group_mode ? flags_o.g_released : '0;
  end

endmodule

/* hw/rtl/multi_input_hold_time_events.sv */
// Hold-time event detector for up to four push inputs. Each input beat is one
// scan: the sampled levels and a millisecond timestamp. The block keeps a press
// start time per input and raises a fired bit the scan that a level's threshold
// is reached (levels in order, a zero threshold ends the ladder), a release bit
// when a press that reached any level ends, and in group mode the shared
// active/reached/hold/released masks. One beat is taken every clock while the
// input register is empty or its scan moves on; each scan's beat is held in the
// input register, goes through the single compare/update pass over all inputs,
// and its result is held in the result register for the result port. A stalled
// output still lets one more scan into the input register, after which input stalls.
// The user must write configuration through the cfg port while no scan is in
// flight; the block does not enforce this, and writes are always accepted.
module multi_input_hold_time_events #(
  parameter int NUM_INPUTS = 4,
  parameter int NUM_LEVELS = 4,
  parameter int TIME_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // scan stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // levels[3:0], now_ms[35:4], zero pad
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // fired_events[15:0], release_events[19:16],
                                      // active_group[23:20], reached_group[39:24],
                                      // hold_group[55:40], released_group[59:56],
                                      // zero pad
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [hte_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hte_pkg::CfgDataW-1:0] cfg_data_i
);
  import hte_pkg::*;

  cfg_t cfg;

  hte_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // input register
  logic                 in_valid_q;
  logic [MaxInputs-1:0] levels_q;
  logic [NowW-1:0]      now_q;
  logic                 advance;

  // result register
  logic                 out_valid_q;
  res_t                 res_q;
  res_t                 res_d;

  // scan state
  flags_t                flags_q, flags_d;
  logic [TIME_WIDTH-1:0] start_q [NUM_INPUTS];
  logic [TIME_WIDTH-1:0] start_d [NUM_INPUTS];

  // a held scan moves on whenever the result slot is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      levels_q <= s_axis_tdata[3:0];
      now_q    <= s_axis_tdata[35:4];
    end
  end

  hte_step #(
    .NUM_INPUTS (NUM_INPUTS),
    .NUM_LEVELS (NUM_LEVELS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_step (
    .cfg_i    (cfg),
    .flags_i  (flags_q),
    .start_i  (start_q),
    .levels_i (levels_q),
    .now_i    (now_q),
    .flags_o  (flags_d),
    .start_o  (start_d),
    .res_o    (res_d)
  );

  // state commits in the same edge that the result is registered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      flags_q     <= flags_d;
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // start times are only read while pressed, which loads them first
  always_ff @(posedge clk_i) begin
    if (advance) begin
      start_q <= start_d;
      res_q   <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, res_q.released, res_q.hold, res_q.reached,
                          res_q.active, res_q.release_ev, res_q.fired};

endmodule

/* hw/rtl/hte_checker.sv */
module hte_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);
  import hte_pkg::*;

  logic [MaxInputs-1:0] fired_any;
  assign fired_any = m_axis_tdata[3:0] | m_axis_tdata[7:4] |
                     m_axis_tdata[11:8] | m_axis_tdata[15:12];

  // stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // an input cannot fire a level and release in the same scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((fired_any & m_axis_tdata[19:16]) == '0))
    else $error("fire and release on one input");

  // a released input is not shown as active
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[23:20] & m_axis_tdata[19:16]) == '0))
    else $error("released input still active");

  // a new result from an empty slot comes from a beat taken into the input register and then the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a scan beat");

endmodule

bind multi_input_hold_time_events hte_checker u_hte_checker (.*);
